// ----- src/cpualu_pkg.sv -----
// package with request and response types, operation codes and flag positions for the cpu alu
`timescale 1ns / 1ps

package cpualu_pkg;

    localparam logic [4:0] MODE_ADD   = 5'd0;
    localparam logic [4:0] MODE_ADC   = 5'd1;
    localparam logic [4:0] MODE_SUB   = 5'd2;
    localparam logic [4:0] MODE_SBC   = 5'd3;
    localparam logic [4:0] MODE_CP    = 5'd4;
    localparam logic [4:0] MODE_AND   = 5'd5;
    localparam logic [4:0] MODE_OR    = 5'd6;
    localparam logic [4:0] MODE_XOR   = 5'd7;
    localparam logic [4:0] MODE_INC   = 5'd8;
    localparam logic [4:0] MODE_DEC   = 5'd9;
    localparam logic [4:0] MODE_RLCA  = 5'd10;
    localparam logic [4:0] MODE_RLA   = 5'd11;
    localparam logic [4:0] MODE_RRCA  = 5'd12;
    localparam logic [4:0] MODE_RRA   = 5'd13;
    localparam logic [4:0] MODE_RLC   = 5'd14;
    localparam logic [4:0] MODE_RL    = 5'd15;
    localparam logic [4:0] MODE_RRC   = 5'd16;
    localparam logic [4:0] MODE_RR    = 5'd17;
    localparam logic [4:0] MODE_SLA   = 5'd18;
    localparam logic [4:0] MODE_SRA   = 5'd19;
    localparam logic [4:0] MODE_SRL   = 5'd20;
    localparam logic [4:0] MODE_SWAP  = 5'd21;
    localparam logic [4:0] MODE_BIT   = 5'd22;
    localparam logic [4:0] MODE_SET   = 5'd23;
    localparam logic [4:0] MODE_RES   = 5'd24;
    localparam logic [4:0] MODE_DAA   = 5'd25;
    localparam logic [4:0] MODE_ADD16 = 5'd26;
    localparam logic [4:0] MODE_SPADD = 5'd27;
    localparam logic [4:0] MODE_INC16 = 5'd28;
    localparam logic [4:0] MODE_DEC16 = 5'd29;

    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    localparam logic [7:0] DAA_LIMIT  = 8'h99;
    localparam logic [7:0] DAA_HI_ADJ = 8'h60;
    localparam logic [7:0] DAA_LO_ADJ = 8'h06;
    localparam logic [3:0] DAA_NIB_MAX = 4'h9;

    typedef struct packed {
        logic [4:0]  mode;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        logic [2:0]  bit_index;
        logic [3:0]  flags_in;
    } alu_req_t;

    typedef struct packed {
        logic [15:0] result;
        logic [3:0]  flags_out;
        logic        write_back;
    } alu_rsp_t;

endpackage

// ----- src/cpu_alu_with_flags_and_daa.sv -----
// top level of the cpu alu: request register, flag and result logic, response register
// a request is taken into the request register, and its response is registered with done
// throughput: one request per cycle, set by the single registered pass through the alu logic
// busy stays low, the receiver cannot stall and each response is shown for one cycle
// reset (rst_n low, asynchronous) clears the valid and done flags, payload is not reset
`timescale 1ns / 1ps

module cpu_alu_with_flags_and_daa
    import cpualu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  alu_req_t req,
    output logic     done,
    output alu_rsp_t rsp
);

    alu_req_t    req_reg;
    logic        vld_reg;
    alu_rsp_t    rsp_reg;
    alu_rsp_t    rsp_next;
    logic        done_reg;

    logic [7:0]  a8;
    logic [7:0]  b8;
    logic [15:0] a16;
    logic [15:0] b16;
    logic [3:0]  fin;
    logic        cin;

    logic [7:0]  b_add;
    logic        c_add;
    logic [8:0]  sum9;
    logic        h_add;
    logic [7:0]  b_sub;
    logic        bw;
    logic [8:0]  diff9;
    logic [4:0]  hdiff5;
    logic [7:0]  mask8;
    logic        daa_hi;
    logic [7:0]  daa_t1;
    logic        daa_lo;
    logic [7:0]  daa_up;
    logic [7:0]  daa_dn;
    logic [7:0]  daa_r;
    logic [16:0] sum17;
    logic [15:0] sp_sum;
    logic [4:0]  nib5;
    logic [8:0]  byte9;
    logic [7:0]  r8;

    assign busy = 1'b0;
    assign done = done_reg;
    assign rsp  = rsp_reg;

    assign a8  = req_reg.operand_a[7:0];
    assign b8  = req_reg.operand_b[7:0];
    assign a16 = req_reg.operand_a;
    assign b16 = req_reg.operand_b;
    assign fin = req_reg.flags_in;
    assign cin = fin[FLAG_C];

    // 8-bit add side
    assign b_add = (req_reg.mode == MODE_INC) ? 8'd1 : b8;
    assign c_add = (req_reg.mode == MODE_ADC) ? cin : 1'b0;
    assign sum9  = {1'b0, a8} + {1'b0, b_add} + {8'd0, c_add};
    assign h_add = sum9[4] ^ a8[4] ^ b_add[4];

    // 8-bit subtract side
    assign b_sub  = (req_reg.mode == MODE_DEC) ? 8'd1 : b8;
    assign bw     = (req_reg.mode == MODE_SBC) ? cin : 1'b0;
    assign diff9  = {1'b0, a8} - {1'b0, b_sub} - {8'd0, bw};
    assign hdiff5 = {1'b0, a8[3:0]} - {1'b0, b_sub[3:0]} - {4'd0, bw};

    assign mask8 = 8'd1 << req_reg.bit_index;

    // decimal adjust
    assign daa_hi = cin | (a8 > DAA_LIMIT);
    assign daa_t1 = a8 + (daa_hi ? DAA_HI_ADJ : 8'd0);
    assign daa_lo = fin[FLAG_H] | (daa_t1[3:0] > DAA_NIB_MAX);
    assign daa_up = daa_t1 + (daa_lo ? DAA_LO_ADJ : 8'd0);
    assign daa_dn = a8 - (cin ? DAA_HI_ADJ : 8'd0) - (fin[FLAG_H] ? DAA_LO_ADJ : 8'd0);
    assign daa_r  = fin[FLAG_N] ? daa_dn : daa_up;

    // 16-bit adds, with the nibble and byte carries for the sp add
    assign sum17  = {1'b0, a16} + {1'b0, b16};
    assign sp_sum = a16 + {{8{b8[7]}}, b8};
    assign nib5   = {1'b0, a8[3:0]} + {1'b0, b8[3:0]};
    assign byte9  = {1'b0, a8} + {1'b0, b8};

    always_comb
    begin
        r8                  = a8;
        rsp_next.result     = {8'd0, a8};
        rsp_next.flags_out  = fin;
        rsp_next.write_back = 1'b1;
        unique case (req_reg.mode)
            MODE_ADD, MODE_ADC, MODE_INC:
            begin
                r8 = sum9[7:0];
                rsp_next.flags_out[FLAG_Z] = (r8 == 8'd0);
                rsp_next.flags_out[FLAG_N] = 1'b0;
                rsp_next.flags_out[FLAG_H] = h_add;
                if (req_reg.mode != MODE_INC)
                begin
                    rsp_next.flags_out[FLAG_C] = sum9[8];
                end
            end
            MODE_SUB, MODE_SBC, MODE_CP, MODE_DEC:
            begin
                r8 = diff9[7:0];
                rsp_next.flags_out[FLAG_Z] = (r8 == 8'd0);
                rsp_next.flags_out[FLAG_N] = 1'b1;
                rsp_next.flags_out[FLAG_H] = hdiff5[4];
                if (req_reg.mode != MODE_DEC)
                begin
                    rsp_next.flags_out[FLAG_C] = diff9[8];
                end
                if (req_reg.mode == MODE_CP)
                begin
                    rsp_next.write_back = 1'b0;
                end
            end
            MODE_AND, MODE_OR, MODE_XOR:
            begin
                if (req_reg.mode == MODE_AND)
                begin
                    r8 = a8 & b8;
                end
                else if (req_reg.mode == MODE_OR)
                begin
                    r8 = a8 | b8;
                end
                else
                begin
                    r8 = a8 ^ b8;
                end
                rsp_next.flags_out = {(r8 == 8'd0), 1'b0, (req_reg.mode == MODE_AND), 1'b0};
            end
            MODE_RLCA, MODE_RLC:
            begin
                r8 = {a8[6:0], a8[7]};
                rsp_next.flags_out = {(req_reg.mode == MODE_RLC) && (r8 == 8'd0), 2'b00, a8[7]};
            end
            MODE_RLA, MODE_RL:
            begin
                r8 = {a8[6:0], cin};
                rsp_next.flags_out = {(req_reg.mode == MODE_RL) && (r8 == 8'd0), 2'b00, a8[7]};
            end
            MODE_RRCA, MODE_RRC:
            begin
                r8 = {a8[0], a8[7:1]};
                rsp_next.flags_out = {(req_reg.mode == MODE_RRC) && (r8 == 8'd0), 2'b00, a8[0]};
            end
            MODE_RRA, MODE_RR:
            begin
                r8 = {cin, a8[7:1]};
                rsp_next.flags_out = {(req_reg.mode == MODE_RR) && (r8 == 8'd0), 2'b00, a8[0]};
            end
            MODE_SLA:
            begin
                r8 = {a8[6:0], 1'b0};
                rsp_next.flags_out = {(r8 == 8'd0), 2'b00, a8[7]};
            end
            MODE_SRA:
            begin
                r8 = {a8[7], a8[7:1]};
                rsp_next.flags_out = {(r8 == 8'd0), 2'b00, a8[0]};
            end
            MODE_SRL:
            begin
                r8 = {1'b0, a8[7:1]};
                rsp_next.flags_out = {(r8 == 8'd0), 2'b00, a8[0]};
            end
            MODE_SWAP:
            begin
                r8 = {a8[3:0], a8[7:4]};
                rsp_next.flags_out = {(r8 == 8'd0), 3'b000};
            end
            MODE_BIT:
            begin
                rsp_next.flags_out[FLAG_Z] = ((a8 & mask8) == 8'd0);
                rsp_next.flags_out[FLAG_N] = 1'b0;
                rsp_next.flags_out[FLAG_H] = 1'b1;
                rsp_next.write_back = 1'b0;
            end
            MODE_SET:
            begin
                r8 = a8 | mask8;
            end
            MODE_RES:
            begin
                r8 = a8 & ~mask8;
            end
            MODE_DAA:
            begin
                r8 = daa_r;
                rsp_next.flags_out[FLAG_Z] = (r8 == 8'd0);
                rsp_next.flags_out[FLAG_H] = 1'b0;
                rsp_next.flags_out[FLAG_C] = fin[FLAG_N] ? cin : daa_hi;
            end
            default:
            begin
                r8 = a8;
            end
        endcase
        rsp_next.result = {8'd0, r8};
        unique case (req_reg.mode)
            MODE_ADD16:
            begin
                rsp_next.result = sum17[15:0];
                rsp_next.flags_out[FLAG_N] = 1'b0;
                rsp_next.flags_out[FLAG_H] = sum17[12] ^ a16[12] ^ b16[12];
                rsp_next.flags_out[FLAG_C] = sum17[16];
            end
            MODE_SPADD:
            begin
                rsp_next.result = sp_sum;
                rsp_next.flags_out = {2'b00, nib5[4], byte9[8]};
            end
            MODE_INC16:
            begin
                rsp_next.result = a16 + 16'd1;
            end
            MODE_DEC16:
            begin
                rsp_next.result = a16 - 16'd1;
            end
            default:
            begin
                if (req_reg.mode > MODE_DEC16)
                begin
                    rsp_next.result     = a16;
                    rsp_next.flags_out  = fin;
                    rsp_next.write_back = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= start && !busy;
            done_reg <= vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= req;
        end
        if (vld_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

// ----- src/cpualu_checker.sv -----
// port checker for the cpu alu and its bind to the top level
`timescale 1ns / 1ps

module cpualu_checker
    import cpualu_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input alu_req_t req,
    input logic     done,
    input alu_rsp_t rsp
);

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("request without response two cycles later");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("response without matching request");

    a_cp_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(req.mode, 2) == MODE_CP || $past(req.mode, 2) == MODE_BIT))
            |-> !rsp.write_back)
        else $error("compare or bit test marked for write back");

    a_byte_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(req.mode, 2) < MODE_ADD16) |-> (rsp.result[15:8] == 8'd0))
        else $error("8-bit operation with nonzero upper byte");

    a_inc16: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(req.mode, 2) == MODE_INC16)
            |-> (rsp.result == 16'($past(req.operand_a, 2) + 16'd1)))
        else $error("inc16 result wrong");

endmodule

bind cpu_alu_with_flags_and_daa cpualu_checker u_cpualu_checker (.*);

// ----- bench/tb_cpu_alu_with_flags_and_daa.sv -----
// self-checking bench for the cpu alu: directed and random requests against a flag-exact predictor
`timescale 1ns / 1ps

module tb_cpu_alu_with_flags_and_daa;
    import cpualu_pkg::*;

    localparam logic [4:0] MODE_SPARE0  = 5'd30;
    localparam logic [4:0] MODE_SPARE1  = 5'd31;
    localparam int         RANDOM_ITEMS = 1000;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         PRINT_LIMIT  = 50;

    class alu_scoreboard;
        alu_rsp_t expected_rsp[$];
        int       errors;

        function new();
            errors = 0;
        endfunction

        function alu_rsp_t predict_alu(alu_req_t q);
            logic [7:0]  a;
            logic [7:0]  b;
            logic [7:0]  d;
            logic [15:0] r;
            logic [3:0]  f;
            logic [8:0]  s9;
            logic [4:0]  h5;
            logic [12:0] h13;
            logic [16:0] s17;
            logic        cin;
            logic        cy;
            logic        wb;
            alu_rsp_t    p;
            a   = q.operand_a[7:0];
            b   = q.operand_b[7:0];
            d   = a;
            f   = q.flags_in;
            cin = f[FLAG_C];
            r   = {8'h00, a};
            wb  = 1'b1;
            case (q.mode)
                MODE_ADD, MODE_ADC, MODE_INC:
                begin
                    if (q.mode == MODE_INC)
                    begin
                        b = 8'h01;
                    end
                    cy = (q.mode == MODE_ADC) ? cin : 1'b0;
                    s9 = {1'b0, a} + {1'b0, b} + {8'h00, cy};
                    h5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cy};
                    r  = {8'h00, s9[7:0]};
                    f[FLAG_Z] = (s9[7:0] == 8'h00);
                    f[FLAG_N] = 1'b0;
                    f[FLAG_H] = h5[4];
                    if (q.mode != MODE_INC)
                    begin
                        f[FLAG_C] = s9[8];
                    end
                end
                MODE_SUB, MODE_SBC, MODE_CP, MODE_DEC:
                begin
                    if (q.mode == MODE_DEC)
                    begin
                        b = 8'h01;
                    end
                    cy = (q.mode == MODE_SBC) ? cin : 1'b0;
                    s9 = {1'b0, a} - {1'b0, b} - {8'h00, cy};
                    h5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, cy};
                    r  = {8'h00, s9[7:0]};
                    f[FLAG_Z] = (s9[7:0] == 8'h00);
                    f[FLAG_N] = 1'b1;
                    f[FLAG_H] = h5[4];
                    if (q.mode != MODE_DEC)
                    begin
                        f[FLAG_C] = s9[8];
                    end
                    if (q.mode == MODE_CP)
                    begin
                        wb = 1'b0;
                    end
                end
                MODE_AND, MODE_OR, MODE_XOR:
                begin
                    if (q.mode == MODE_AND)
                    begin
                        d = a & b;
                    end
                    else if (q.mode == MODE_OR)
                    begin
                        d = a | b;
                    end
                    else
                    begin
                        d = a ^ b;
                    end
                    r = {8'h00, d};
                    f = 4'h0;
                    f[FLAG_Z] = (d == 8'h00);
                    f[FLAG_H] = (q.mode == MODE_AND);
                end
                MODE_RLCA, MODE_RLA, MODE_RRCA, MODE_RRA, MODE_RLC, MODE_RL, MODE_RRC,
                MODE_RR, MODE_SLA, MODE_SRA, MODE_SRL:
                begin
                    case (q.mode)
                        MODE_RLCA, MODE_RLC:
                        begin
                            d  = {a[6:0], a[7]};
                            cy = a[7];
                        end
                        MODE_RLA, MODE_RL:
                        begin
                            d  = {a[6:0], cin};
                            cy = a[7];
                        end
                        MODE_RRCA, MODE_RRC:
                        begin
                            d  = {a[0], a[7:1]};
                            cy = a[0];
                        end
                        MODE_RRA, MODE_RR:
                        begin
                            d  = {cin, a[7:1]};
                            cy = a[0];
                        end
                        MODE_SLA:
                        begin
                            d  = {a[6:0], 1'b0};
                            cy = a[7];
                        end
                        MODE_SRA:
                        begin
                            d  = {a[7], a[7:1]};
                            cy = a[0];
                        end
                        default:
                        begin
                            d  = {1'b0, a[7:1]};
                            cy = a[0];
                        end
                    endcase
                    r = {8'h00, d};
                    f = 4'h0;
                    f[FLAG_C] = cy;
                    // accumulator rotates always clear zero
                    if (q.mode >= MODE_RLC && d == 8'h00)
                    begin
                        f[FLAG_Z] = 1'b1;
                    end
                end
                MODE_SWAP:
                begin
                    d = {a[3:0], a[7:4]};
                    r = {8'h00, d};
                    f = 4'h0;
                    f[FLAG_Z] = (d == 8'h00);
                end
                MODE_BIT:
                begin
                    f[FLAG_Z] = ~a[q.bit_index];
                    f[FLAG_N] = 1'b0;
                    f[FLAG_H] = 1'b1;
                    wb = 1'b0;
                end
                MODE_SET:
                begin
                    r = {8'h00, a | (8'h01 << q.bit_index)};
                end
                MODE_RES:
                begin
                    r = {8'h00, a & ~(8'h01 << q.bit_index)};
                end
                MODE_DAA:
                begin
                    if (!f[FLAG_N])
                    begin
                        if (f[FLAG_C] || d > DAA_LIMIT)
                        begin
                            d = d + DAA_HI_ADJ;
                            f[FLAG_C] = 1'b1;
                        end
                        if (f[FLAG_H] || d[3:0] > DAA_NIB_MAX)
                        begin
                            d = d + DAA_LO_ADJ;
                        end
                    end
                    else
                    begin
                        if (f[FLAG_C])
                        begin
                            d = d - DAA_HI_ADJ;
                        end
                        if (f[FLAG_H])
                        begin
                            d = d - DAA_LO_ADJ;
                        end
                    end
                    r = {8'h00, d};
                    f[FLAG_Z] = (d == 8'h00);
                    f[FLAG_H] = 1'b0;
                end
                MODE_ADD16:
                begin
                    s17 = {1'b0, q.operand_a} + {1'b0, q.operand_b};
                    h13 = {1'b0, q.operand_a[11:0]} + {1'b0, q.operand_b[11:0]};
                    r   = s17[15:0];
                    f[FLAG_N] = 1'b0;
                    f[FLAG_H] = h13[12];
                    f[FLAG_C] = s17[16];
                end
                MODE_SPADD:
                begin
                    r  = q.operand_a + {{8{b[7]}}, b};
                    h5 = {1'b0, q.operand_a[3:0]} + {1'b0, b[3:0]};
                    s9 = {1'b0, q.operand_a[7:0]} + {1'b0, b};
                    f  = 4'h0;
                    f[FLAG_H] = h5[4];
                    f[FLAG_C] = s9[8];
                end
                MODE_INC16:
                begin
                    r = q.operand_a + 16'h0001;
                end
                MODE_DEC16:
                begin
                    r = q.operand_a - 16'h0001;
                end
                default:
                begin
                    r  = q.operand_a;
                    wb = 1'b0;
                end
            endcase
            p.result     = r;
            p.flags_out  = f;
            p.write_back = wb;
            return p;
        endfunction

        function void note_request(alu_req_t q);
            expected_rsp.push_back(predict_alu(q));
        endfunction

        task report(string what, logic [15:0] got, logic [15:0] want);
            errors++;
            if (errors <= PRINT_LIMIT)
            begin
                $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
            end
        endtask

        task check_response(alu_rsp_t got);
            alu_rsp_t want;
            if (expected_rsp.size() == 0)
            begin
                report("response with no request outstanding", got.result, 16'h0000);
            end
            else
            begin
                want = expected_rsp.pop_front();
                if (got.result !== want.result)
                begin
                    report("result", got.result, want.result);
                end
                if (got.flags_out !== want.flags_out)
                begin
                    report("flags_out", {12'h000, got.flags_out}, {12'h000, want.flags_out});
                end
                if (got.write_back !== want.write_back)
                begin
                    report("write_back", {15'h0000, got.write_back}, {15'h0000, want.write_back});
                end
            end
        endtask
    endclass

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    alu_req_t      req;
    logic          done;
    alu_rsp_t      rsp;
    alu_scoreboard sb;
    int            accepted;
    int            cycles;

    cpu_alu_with_flags_and_daa u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                sb.note_request(req);
                accepted++;
            end
            if (done)
            begin
                sb.check_response(rsp);
            end
        end
    end

    function logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return {8'h00, 8'($urandom)};
            3:       return {8'($urandom), 8'hFF};
            4:       return {8'($urandom), 8'h00};
            default: return 16'($urandom);
        endcase
    endfunction

    // well-formed daa input: the raw sum or difference of two bcd bytes with its flags
    function alu_req_t bcd_daa_request();
        logic [7:0] x;
        logic [7:0] y;
        logic [8:0] s9;
        logic [4:0] h5;
        alu_req_t   q;
        x = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
        y = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
        q.mode      = MODE_DAA;
        q.operand_b = 16'($urandom);
        q.bit_index = 3'($urandom);
        q.flags_in  = 4'h0;
        q.flags_in[FLAG_Z] = 1'($urandom);
        if ($urandom_range(0, 1) == 0)
        begin
            s9 = {1'b0, x} + {1'b0, y};
            h5 = {1'b0, x[3:0]} + {1'b0, y[3:0]};
        end
        else
        begin
            s9 = {1'b0, x} - {1'b0, y};
            h5 = {1'b0, x[3:0]} - {1'b0, y[3:0]};
            q.flags_in[FLAG_N] = 1'b1;
        end
        q.flags_in[FLAG_H] = h5[4];
        q.flags_in[FLAG_C] = s9[8];
        q.operand_a = {8'($urandom), s9[7:0]};
        return q;
    endfunction

    function alu_req_t random_request();
        alu_req_t q;
        if ($urandom_range(0, 99) < 4)
        begin
            q.mode = ($urandom_range(0, 1) == 0) ? MODE_SPARE0 : MODE_SPARE1;
        end
        else
        begin
            q.mode = 5'($urandom_range(MODE_ADD, MODE_DEC16));
        end
        if (q.mode == MODE_DAA && $urandom_range(0, 2) != 0)
        begin
            return bcd_daa_request();
        end
        q.operand_a = pick_word();
        q.operand_b = pick_word();
        q.bit_index = 3'($urandom);
        q.flags_in  = 4'($urandom);
        return q;
    endfunction

    task send_request(alu_req_t q);
        int n;
        n = accepted;
        start <= 1'b1;
        req   <= q;
        do
        begin
            @(negedge clk);
        end
        while (accepted == n);
    endtask

    task issue(logic [4:0] m, logic [15:0] a, logic [15:0] b, logic [2:0] bi, logic [3:0] f);
        alu_req_t q;
        q.mode      = m;
        q.operand_a = a;
        q.operand_b = b;
        q.bit_index = bi;
        q.flags_in  = f;
        send_request(q);
    endtask

    initial
    begin
        int sent;
        int burst;
        sb       = new();
        accepted = 0;
        cycles   = 0;
        sent     = 0;
        rst_n    = 1'b0;
        start    = 1'b0;
        req      = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        issue(MODE_ADD,    16'hAAFF, 16'h5501, 3'd0, 4'h0);
        issue(MODE_ADC,    16'h00FF, 16'hFF00, 3'd7, 4'h1);
        issue(MODE_SUB,    16'h0000, 16'h0001, 3'd0, 4'hF);
        issue(MODE_SBC,    16'hFF10, 16'h000F, 3'd0, 4'h1);
        issue(MODE_CP,     16'h003C, 16'h003C, 3'd0, 4'h0);
        issue(MODE_AND,    16'h00F0, 16'h000F, 3'd0, 4'hF);
        issue(MODE_OR,     16'h0000, 16'h0000, 3'd0, 4'h7);
        issue(MODE_XOR,    16'h12FF, 16'h34FF, 3'd0, 4'hF);
        issue(MODE_INC,    16'h00FF, 16'hFFFF, 3'd0, 4'h1);
        issue(MODE_DEC,    16'h0010, 16'hFFFF, 3'd0, 4'h0);
        issue(MODE_RLCA,   16'h0000, 16'h0000, 3'd0, 4'h8);
        issue(MODE_RLA,    16'h0080, 16'h0000, 3'd0, 4'h1);
        issue(MODE_RRCA,   16'h0001, 16'h0000, 3'd0, 4'hF);
        issue(MODE_RR,     16'h0001, 16'h0000, 3'd0, 4'h0);
        issue(MODE_RLC,    16'h0000, 16'h0000, 3'd0, 4'h7);
        issue(MODE_SRA,    16'h0081, 16'h0000, 3'd0, 4'h0);
        issue(MODE_SRL,    16'h0001, 16'h0000, 3'd0, 4'hF);
        issue(MODE_SWAP,   16'h00F0, 16'h0000, 3'd0, 4'hF);
        issue(MODE_BIT,    16'h007F, 16'h0000, 3'd7, 4'h5);
        issue(MODE_SET,    16'h0000, 16'h0000, 3'd7, 4'hA);
        issue(MODE_RES,    16'hFFFF, 16'hFFFF, 3'd0, 4'h5);
        issue(MODE_DAA,    16'h009A, 16'h0000, 3'd0, 4'h0);
        issue(MODE_DAA,    16'h0000, 16'h0000, 3'd0, 4'h7);
        issue(MODE_ADD16,  16'hFFFF, 16'h0001, 3'd0, 4'h8);
        issue(MODE_SPADD,  16'hFFFF, 16'h00FF, 3'd0, 4'hF);
        issue(MODE_INC16,  16'hFFFF, 16'h0000, 3'd0, 4'h3);
        issue(MODE_DEC16,  16'h0000, 16'h0000, 3'd0, 4'hC);
        issue(MODE_SPARE1, 16'hBEEF, 16'h1234, 3'd5, 4'h9);

        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 24);
            repeat (burst)
            begin
                send_request(random_request());
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
            end
        end
        start <= 1'b0;

        while (sb.expected_rsp.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (6) @(negedge clk);
        if (sb.errors == 0 && sb.expected_rsp.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
